/* hdl/srd_pkg.sv */
// ----------------------------------------------------------------------------
// srd_pkg
// Types and constants shared by the scan range delete-subtract block.
// ----------------------------------------------------------------------------
package srd_pkg;

	localparam int unsigned DATA_W  = 64;
	localparam int unsigned TDATA_W = 4 * DATA_W;
	localparam int unsigned ADDR_W  = 5;

	localparam logic signed [DATA_W-1:0] TS_MIN  = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] TS_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic        [DATA_W-1:0] SEQ_MAX = {DATA_W{1'b1}};

	// piece kinds, bit positions in the piece mask, in emit order
	localparam int unsigned K_PASS  = 0;
	localparam int unsigned K_LOWER = 1;
	localparam int unsigned K_UPPER = 2;
	localparam int unsigned K_MID   = 3;
	localparam int unsigned K_FRONT = 4;
	localparam int unsigned K_BACK  = 5;
	localparam int unsigned NUM_KINDS = 6;

	typedef logic [NUM_KINDS-1:0] srd_mask_t;

	typedef enum logic [1:0] {
		REG_DEL_TS_BEGIN  = 2'd0,
		REG_DEL_TS_END    = 2'd1,
		REG_DEL_SEQ_BEGIN = 2'd2,
		REG_DEL_SEQ_END   = 2'd3
	} srd_reg_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] ts_begin;
		logic signed [DATA_W-1:0] ts_end;
		logic        [DATA_W-1:0] seq_begin;
		logic        [DATA_W-1:0] seq_end;
	} srd_cfg_t;

	// all candidate pieces of one scan, selected by mask
	typedef struct packed {
		srd_mask_t                mask;
		logic signed [DATA_W-1:0] tb;
		logic signed [DATA_W-1:0] te;
		logic signed [DATA_W-1:0] cb;
		logic signed [DATA_W-1:0] ce;
		logic signed [DATA_W-1:0] front_end;
		logic signed [DATA_W-1:0] back_begin;
		logic        [DATA_W-1:0] sb;
		logic        [DATA_W-1:0] se;
		logic        [DATA_W-1:0] lo;
		logic        [DATA_W-1:0] hi;
	} srd_pieces_t;

endpackage

/* hdl/scan_range_delete_subtract_core.sv */
// ----------------------------------------------------------------------------
// scan_range_delete_subtract_core
// Subtracts a configured delete rectangle from each scan rectangle.
// ----------------------------------------------------------------------------
// Usage:
//   The delete rectangle is set over the APB port (64-bit registers at byte
//   addresses 0, 8, 16, 24: ts begin, ts end, seq begin, seq end); the user
//   must write it only while the block is idle, which it does not enforce.
//   Each scan request enters on the s_ stream and yields zero to four result
//   requests on the m_ stream, m_tlast on the final one. A scan that yields
//   nothing produces no output beat.
// Each result passes the input register, then the result buffer.
// Throughput: the result buffer drains one piece per cycle while m_tready is
//   high, and the next scan is loaded in the cycle its last piece is taken.
// Reset: clears the delete rectangle to zero and drops any pending scan.
// Stall: while m_tready is low the result holds; one further scan waits in
//   the input register and s_tready then drops.
// ----------------------------------------------------------------------------
module scan_range_delete_subtract_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [63:0] scan_ts_begin, [127:64] scan_ts_end,
	// [191:128] scan_seq_begin, [255:192] scan_seq_end
	input  logic [255:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [63:0] out_ts_begin, [127:64] out_ts_end,
	// [191:128] out_seq_begin, [255:192] out_seq_end
	output logic [255:0] m_tdata,
	output logic         m_tlast,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready
);
	import srd_pkg::*;

	srd_cfg_t    cfg;
	srd_pieces_t pieces;
	logic        pieces_valid;
	logic        take;

	srd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	srd_split u_split (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.cfg          (cfg),
		.take         (take),
		.pieces_valid (pieces_valid),
		.pieces       (pieces)
	);

	srd_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.pieces_valid (pieces_valid),
		.pieces       (pieces),
		.take         (take),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast)
	);

	a_piece_count: assert property (@(posedge clk) disable iff (!arst_n)
		pieces_valid |-> $countones(pieces.mask) <= 4)
		else $error("more than four pieces for one scan");

	a_pass_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(pieces_valid && pieces.mask[K_PASS]) |-> $onehot(pieces.mask))
		else $error("pass-through piece combined with split pieces");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> (!m_tvalid || (m_tready && m_tlast)))
		else $error("result buffer reloaded with pieces pending");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
		else $error("result run ended without last marker");

endmodule

/* hdl/srd_regs.sv */
// ----------------------------------------------------------------------------
// srd_regs
// APB register file holding the delete rectangle.
// ----------------------------------------------------------------------------
module srd_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [srd_pkg::ADDR_W-1:0]     paddr,
	input  logic [srd_pkg::DATA_W-1:0]     pwdata,
	output logic [srd_pkg::DATA_W-1:0]     prdata,
	output logic                           pready,
	output srd_pkg::srd_cfg_t              cfg
);
	import srd_pkg::*;

	srd_cfg_t cfg_q;
	srd_reg_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = srd_reg_t'(paddr[ADDR_W-1:3]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_DEL_TS_BEGIN:  cfg_q.ts_begin  <= pwdata;
				REG_DEL_TS_END:    cfg_q.ts_end    <= pwdata;
				REG_DEL_SEQ_BEGIN: cfg_q.seq_begin <= pwdata;
				REG_DEL_SEQ_END:   cfg_q.seq_end   <= pwdata;
				default:           cfg_q           <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_DEL_TS_BEGIN:  prdata = cfg_q.ts_begin;
			REG_DEL_TS_END:    prdata = cfg_q.ts_end;
			REG_DEL_SEQ_BEGIN: prdata = cfg_q.seq_begin;
			REG_DEL_SEQ_END:   prdata = cfg_q.seq_end;
			default:           prdata = '0;
		endcase
	end

endmodule

/* hdl/srd_split.sv */
// ----------------------------------------------------------------------------
// srd_split
// Input register and piece selection: one scan rectangle becomes a mask of
// remaining pieces plus the bounds they are built from.
// ----------------------------------------------------------------------------
module srd_split (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [srd_pkg::TDATA_W-1:0]    s_tdata,
	input  srd_pkg::srd_cfg_t              cfg,
	input  logic                           take,
	output logic                           pieces_valid,
	output srd_pkg::srd_pieces_t           pieces
);
	import srd_pkg::*;

	logic                     valid_s1;
	logic signed [DATA_W-1:0] tb_s1, te_s1;
	logic        [DATA_W-1:0] sb_s1, se_s1;

	logic miss, encl, lower, upper, mid, front, back;
	logic signed [DATA_W-1:0] cb, ce;
	logic        [DATA_W-1:0] lo, hi;

	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			tb_s1 <= s_tdata[DATA_W-1:0];
			te_s1 <= s_tdata[2*DATA_W-1:DATA_W];
			sb_s1 <= s_tdata[3*DATA_W-1:2*DATA_W];
			se_s1 <= s_tdata[4*DATA_W-1:3*DATA_W];
		end
	end

	always_comb begin
		miss  = (te_s1 < cfg.ts_begin) || (tb_s1 > cfg.ts_end);
		cb    = (tb_s1 > cfg.ts_begin) ? tb_s1 : cfg.ts_begin;
		ce    = (te_s1 < cfg.ts_end) ? te_s1 : cfg.ts_end;
		lo    = (cfg.seq_begin == '0) ? '0 : cfg.seq_begin - 1'b1;
		hi    = (cfg.seq_end == SEQ_MAX) ? SEQ_MAX : cfg.seq_end + 1'b1;
		encl  = (sb_s1 <= cfg.seq_begin) && (cfg.seq_end <= se_s1);
		if (encl) begin
			lower = sb_s1 < cfg.seq_begin;
			upper = se_s1 > cfg.seq_end;
			mid   = 1'b0;
		end else begin
			lower = (sb_s1 <= cfg.seq_begin) && (cfg.seq_begin <= se_s1) && (sb_s1 <= lo);
			upper = (sb_s1 <= cfg.seq_end) && (cfg.seq_end <= se_s1) && (hi <= se_s1);
			mid   = (cfg.seq_end < sb_s1) || (cfg.seq_begin > se_s1);
		end
		// front/back pieces exist only when the overlap edge is the delete edge
		front = cb > tb_s1;
		back  = ce < te_s1;

		pieces.mask           = '0;
		pieces.mask[K_PASS]   = miss;
		pieces.mask[K_LOWER]  = !miss && lower;
		pieces.mask[K_UPPER]  = !miss && upper;
		pieces.mask[K_MID]    = !miss && mid;
		pieces.mask[K_FRONT]  = !miss && front;
		pieces.mask[K_BACK]   = !miss && back;
		pieces.tb             = tb_s1;
		pieces.te             = te_s1;
		pieces.cb             = cb;
		pieces.ce             = ce;
		pieces.front_end      = (cb == TS_MIN) ? TS_MIN : cb - 1'b1;
		pieces.back_begin     = (ce == TS_MAX) ? TS_MAX : ce + 1'b1;
		pieces.sb             = sb_s1;
		pieces.se             = se_s1;
		pieces.lo             = lo;
		pieces.hi             = hi;
	end

	assign pieces_valid = valid_s1;

endmodule

/* hdl/srd_emit.sv */
// ----------------------------------------------------------------------------
// srd_emit
// Result buffer and sequencer: sends the pieces of one scan, lowest mask bit
// first, one per cycle while m_tready is high, marking the final one.
// ----------------------------------------------------------------------------
module srd_emit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pieces_valid,
	input  srd_pkg::srd_pieces_t           pieces,
	output logic                           take,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [srd_pkg::TDATA_W-1:0]    m_tdata,
	output logic                           m_tlast
);
	import srd_pkg::*;

	srd_pieces_t buf_q;
	srd_mask_t   mask_q;
	logic        fire;
	logic        buf_free;
	logic signed [DATA_W-1:0] o_tb, o_te;
	logic        [DATA_W-1:0] o_sb, o_se;

	assign m_tvalid = mask_q != '0;
	assign m_tlast  = (mask_q & (mask_q - 1'b1)) == '0;
	assign fire     = m_tvalid && m_tready;
	assign buf_free = !m_tvalid || (fire && m_tlast);
	assign take     = buf_free && pieces_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (take) begin
			mask_q <= pieces.mask;
		end else if (fire) begin
			mask_q <= mask_q & (mask_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			buf_q <= pieces;
		end
	end

	always_comb begin
		o_tb = buf_q.cb;
		o_te = buf_q.ce;
		o_sb = buf_q.sb;
		o_se = buf_q.se;
		if (mask_q[K_PASS]) begin
			o_tb = buf_q.tb;
			o_te = buf_q.te;
		end else if (mask_q[K_LOWER]) begin
			o_se = buf_q.lo;
		end else if (mask_q[K_UPPER]) begin
			o_sb = buf_q.hi;
		end else if (mask_q[K_MID]) begin
			o_tb = buf_q.cb;
		end else if (mask_q[K_FRONT]) begin
			o_tb = buf_q.tb;
			o_te = buf_q.front_end;
		end else begin
			o_tb = buf_q.back_begin;
			o_te = buf_q.te;
		end
	end

	assign m_tdata = {o_se, o_sb, o_te, o_tb};

endmodule
